>>> hdl/lpr_pkg.sv
// Shared types, constants and tables for the lidar point re-origin block.
package lpr_pkg;

    // Parameter defaults
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int MAX_BEAMS_DEF     = 4096;

    // Field and datapath widths
    localparam int RANGE_W   = 16;
    localparam int BEAM_W    = 12;
    localparam int ANGLE_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int XY_W      = 35;  // rotated vector, 2^-16 mm
    localparam int Z_W       = 25;  // residual angle, 2^-24 turn
    localparam int ATAN_W    = 22;
    localparam int ATAN_LEN  = 24;
    localparam int PROD_W    = 51;  // one partial product of the gain multiply
    localparam int SUM_W     = 66;  // full gain product
    localparam int POS_W     = 24;  // x and y on base, 1/16 mm
    localparam int MAG_W     = 23;
    localparam int SQ_N_W    = 48;
    localparam int SQ_ROOT_W = 24;
    localparam int SQ_REM_W  = 26;

    // Gain removal: 1/K in Q30, split into two partial products
    localparam longint INV_GAIN = 64'd652032874;
    localparam int     G_SPLIT  = 15;
    localparam logic [15:0] GAIN_HI = 16'(INV_GAIN >> G_SPLIT);
    localparam logic [15:0] GAIN_LO = 16'(INV_GAIN % (64'd1 << G_SPLIT));
    localparam int     GAIN_SHIFT = 42;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOUNT_YAW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET    = 3'd4;

    // Sideband carried alongside every stage
    typedef struct packed {
        logic valid;
        logic inf;
        logic last;
    } lpr_side_t;

    // Arctangent table, 2^-24 turn
    function automatic logic [ATAN_W-1:0] atan_val(input int i);
        logic [ATAN_W-1:0] v;
        case (i)
            0: v = 22'd2097152;
            1: v = 22'd1238021;
            2: v = 22'd654136;
            3: v = 22'd332050;
            4: v = 22'd166669;
            5: v = 22'd83416;
            6: v = 22'd41718;
            7: v = 22'd20860;
            8: v = 22'd10430;
            9: v = 22'd5215;
            10: v = 22'd2608;
            11: v = 22'd1304;
            12: v = 22'd652;
            13: v = 22'd326;
            14: v = 22'd163;
            15: v = 22'd81;
            16: v = 22'd41;
            17: v = 22'd20;
            18: v = 22'd10;
            19: v = 22'd5;
            20: v = 22'd3;
            21: v = 22'd1;
            22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/lpr_cordic_cell.sv
// One CORDIC rotation cell of the chain.
module lpr_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  lpr_pkg::lpr_side_t                  side_in,
    input  logic signed [lpr_pkg::XY_W-1:0]     x_in,
    input  logic signed [lpr_pkg::XY_W-1:0]     y_in,
    input  logic signed [lpr_pkg::Z_W-1:0]      z_in,
    output lpr_pkg::lpr_side_t                  side_out,
    output logic signed [lpr_pkg::XY_W-1:0]     x_out,
    output logic signed [lpr_pkg::XY_W-1:0]     y_out,
    output logic signed [lpr_pkg::Z_W-1:0]      z_out
);

    localparam logic signed [lpr_pkg::Z_W-1:0] ATAN =
        lpr_pkg::Z_W'(lpr_pkg::atan_val(IDX));

    logic signed [lpr_pkg::XY_W-1:0] dx, dy, x_next, y_next;
    logic signed [lpr_pkg::Z_W-1:0]  z_next;
    lpr_pkg::lpr_side_t              side_reg;
    logic signed [lpr_pkg::XY_W-1:0] x_reg, y_reg;
    logic signed [lpr_pkg::Z_W-1:0]  z_reg;

    // Rotate towards zero residual angle
    always_comb
    begin
        dx = y_in >>> IDX;
        dy = x_in >>> IDX;
        if (!z_in[lpr_pkg::Z_W-1])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
    end

    // Hold sideband
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= '0;
        else if (en)
            side_reg <= side_in;
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign side_out = side_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;

endmodule

>>> hdl/lpr_sqrt_cell.sv
// One digit cell of the restoring integer square root chain.
module lpr_sqrt_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  lpr_pkg::lpr_side_t                 side_in,
    input  logic [lpr_pkg::SQ_N_W-1:0]         n_in,
    input  logic [lpr_pkg::SQ_REM_W-1:0]       rem_in,
    input  logic [lpr_pkg::SQ_ROOT_W-1:0]      root_in,
    output lpr_pkg::lpr_side_t                 side_out,
    output logic [lpr_pkg::SQ_N_W-1:0]         n_out,
    output logic [lpr_pkg::SQ_REM_W-1:0]       rem_out,
    output logic [lpr_pkg::SQ_ROOT_W-1:0]      root_out
);

    logic [lpr_pkg::SQ_REM_W-1:0]  rem_sh, trial, rem_next;
    logic [lpr_pkg::SQ_ROOT_W-1:0] root_next;
    lpr_pkg::lpr_side_t            side_reg;
    logic [lpr_pkg::SQ_N_W-1:0]    n_reg;
    logic [lpr_pkg::SQ_REM_W-1:0]  rem_reg;
    logic [lpr_pkg::SQ_ROOT_W-1:0] root_reg;

    // Bring down two radicand bits and try the next root bit
    always_comb
    begin
        rem_sh = {rem_in[lpr_pkg::SQ_REM_W-3:0],
                  n_in[lpr_pkg::SQ_N_W-1:lpr_pkg::SQ_N_W-2]};
        trial  = {root_in, 2'b01};
        if (rem_sh >= trial)
        begin
            rem_next  = rem_sh - trial;
            root_next = {root_in[lpr_pkg::SQ_ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh;
            root_next = {root_in[lpr_pkg::SQ_ROOT_W-2:0], 1'b0};
        end
    end

    // Hold sideband
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_reg <= '0;
        else if (en)
            side_reg <= side_in;
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg    <= {n_in[lpr_pkg::SQ_N_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign side_out = side_reg;
    assign n_out    = n_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

>>> hdl/lidar_point_reorigin_top.sv
// Top level of the lidar point re-origin block: front end, cell chains, output.
// Takes one sample per cycle when the output side keeps up; each sample passes
// through the front end, the chain of CORDIC cells, a gain multiply, and the
// 24-cell square-root chain. The whole pipeline
// advances together and halts only while a finished word waits unaccepted at
// the output. Configuration must be written while no sample is in flight.
module lidar_point_reorigin_top #(
    parameter int CORDIC_STAGES = lpr_pkg::CORDIC_STAGES_DEF,
    parameter int MAX_BEAMS     = lpr_pkg::MAX_BEAMS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,  // range_mm, beam_index, zero pad
    input  logic [0:0]                      s_tuser,  // range_infinite
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,  // base_range_mm
    output logic [1:0]                      m_tuser,  // out_infinite, saturated
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [lpr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lpr_pkg::CFG_W-1:0]       cfg_data
);

    localparam logic [16:0] BEAM_LIM = 17'(MAX_BEAMS - 1);
    localparam int NSQ = lpr_pkg::SQ_ROOT_W;
    localparam logic signed [lpr_pkg::PROD_W-1:0] GAIN_HI_S =
        lpr_pkg::PROD_W'(lpr_pkg::GAIN_HI);
    localparam logic signed [lpr_pkg::PROD_W-1:0] GAIN_LO_S =
        lpr_pkg::PROD_W'(lpr_pkg::GAIN_LO);

    logic en;

    // Configuration registers
    logic [lpr_pkg::ANGLE_W-1:0] angle_start_reg, angle_step_reg, mount_yaw_reg;
    logic signed [15:0]          x_offset_reg, y_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_start_reg <= 16'd32768;
            angle_step_reg  <= 16'd0;
            mount_yaw_reg   <= 16'd0;
            x_offset_reg    <= 16'sd115;
            y_offset_reg    <= -16'sd168;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lpr_pkg::REG_ANGLE_START: angle_start_reg <= cfg_data;
                lpr_pkg::REG_ANGLE_STEP:  angle_step_reg  <= cfg_data;
                lpr_pkg::REG_MOUNT_YAW:   mount_yaw_reg   <= cfg_data;
                lpr_pkg::REG_X_OFFSET:    x_offset_reg    <= cfg_data;
                lpr_pkg::REG_Y_OFFSET:    y_offset_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 0: clamp beam index, multiply by step
    lpr_pkg::lpr_side_t s0_side_reg;
    logic [15:0]        s0_prod_reg;
    logic [15:0]        s0_range_reg;
    logic [11:0]        beam_c;
    logic [27:0]        beam_prod;

    always_comb
    begin
        beam_c = ({5'd0, s_tdata[27:16]} > BEAM_LIM) ? BEAM_LIM[11:0] : s_tdata[27:16];
        beam_prod = beam_c * angle_step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_side_reg <= '0;
        else if (en)
            s0_side_reg <= '{valid: s_tvalid, inf: s_tuser[0], last: s_tlast};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_prod_reg  <= beam_prod[15:0];
            s0_range_reg <= s_tdata[15:0];
        end
    end

    // Stage 1: beam angle, quadrant pre-rotation
    lpr_pkg::lpr_side_t              s1_side_reg;
    logic signed [lpr_pkg::XY_W-1:0] s1_x_reg, s1_y_reg;
    logic signed [lpr_pkg::Z_W-1:0]  s1_z_reg;
    logic [15:0]                     ang, ang_q, ang_r;
    logic [1:0]                      quad;
    logic signed [lpr_pkg::XY_W-1:0] r_pos, x_init, y_init;

    always_comb
    begin
        ang   = angle_start_reg + s0_prod_reg - mount_yaw_reg;
        ang_q = ang + 16'd8192;
        quad  = ang_q[15:14];
        ang_r = ang - {quad, 14'd0};
        r_pos = lpr_pkg::XY_W'({s0_range_reg, 16'd0});
        case (quad)
            2'd0:    begin x_init = r_pos;  y_init = '0;     end
            2'd1:    begin x_init = '0;     y_init = r_pos;  end
            2'd2:    begin x_init = -r_pos; y_init = '0;     end
            default: begin x_init = '0;     y_init = -r_pos; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_side_reg <= '0;
        else if (en)
            s1_side_reg <= s0_side_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x_reg <= x_init;
            s1_y_reg <= y_init;
            s1_z_reg <= {{(lpr_pkg::Z_W-24){ang_r[15]}}, ang_r, 8'd0};
        end
    end

    // CORDIC cell chain
    lpr_pkg::lpr_side_t              c_side [CORDIC_STAGES+1];
    logic signed [lpr_pkg::XY_W-1:0] c_x    [CORDIC_STAGES+1];
    logic signed [lpr_pkg::XY_W-1:0] c_y    [CORDIC_STAGES+1];
    logic signed [lpr_pkg::Z_W-1:0]  c_z    [CORDIC_STAGES+1];

    assign c_side[0] = s1_side_reg;
    assign c_x[0]    = s1_x_reg;
    assign c_y[0]    = s1_y_reg;
    assign c_z[0]    = s1_z_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        lpr_cordic_cell #(.IDX(i)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .side_in  (c_side[i]),
            .x_in     (c_x[i]),
            .y_in     (c_y[i]),
            .z_in     (c_z[i]),
            .side_out (c_side[i+1]),
            .x_out    (c_x[i+1]),
            .y_out    (c_y[i+1]),
            .z_out    (c_z[i+1])
        );
    end

    // Gain stage A: partial products
    lpr_pkg::lpr_side_t                g1_side_reg;
    logic signed [lpr_pkg::PROD_W-1:0] g1_xh_reg, g1_xl_reg, g1_yh_reg, g1_yl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g1_side_reg <= '0;
        else if (en)
            g1_side_reg <= c_side[CORDIC_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g1_xh_reg <= lpr_pkg::PROD_W'(c_x[CORDIC_STAGES]) * GAIN_HI_S;
            g1_xl_reg <= lpr_pkg::PROD_W'(c_x[CORDIC_STAGES]) * GAIN_LO_S;
            g1_yh_reg <= lpr_pkg::PROD_W'(c_y[CORDIC_STAGES]) * GAIN_HI_S;
            g1_yl_reg <= lpr_pkg::PROD_W'(c_y[CORDIC_STAGES]) * GAIN_LO_S;
        end
    end

    // Gain stage B: combine, round, add mounting offsets
    lpr_pkg::lpr_side_t               g2_side_reg;
    logic signed [lpr_pkg::POS_W-1:0] g2_x_reg, g2_y_reg;
    logic signed [lpr_pkg::SUM_W-1:0] sum_x, sum_y;
    localparam logic signed [lpr_pkg::SUM_W-1:0] HALF =
        lpr_pkg::SUM_W'(64'd1 << (lpr_pkg::GAIN_SHIFT - 1));

    always_comb
    begin
        sum_x = (lpr_pkg::SUM_W'(g1_xh_reg) <<< lpr_pkg::G_SPLIT)
              + lpr_pkg::SUM_W'(g1_xl_reg) + HALF;
        sum_y = (lpr_pkg::SUM_W'(g1_yh_reg) <<< lpr_pkg::G_SPLIT)
              + lpr_pkg::SUM_W'(g1_yl_reg) + HALF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g2_side_reg <= '0;
        else if (en)
            g2_side_reg <= g1_side_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g2_x_reg <= sum_x[lpr_pkg::GAIN_SHIFT +: lpr_pkg::POS_W]
                      + (lpr_pkg::POS_W'(x_offset_reg) <<< 4);
            g2_y_reg <= sum_y[lpr_pkg::GAIN_SHIFT +: lpr_pkg::POS_W]
                      + (lpr_pkg::POS_W'(y_offset_reg) <<< 4);
        end
    end

    // Square stage: sum of squares
    lpr_pkg::lpr_side_t        q_side_reg;
    logic [lpr_pkg::SQ_N_W-1:0] q_n_reg;
    logic [lpr_pkg::POS_W-1:0]  abs_x, abs_y;
    logic [2*lpr_pkg::MAG_W-1:0] sq_x, sq_y;

    always_comb
    begin
        abs_x = g2_x_reg[lpr_pkg::POS_W-1] ? -g2_x_reg : g2_x_reg;
        abs_y = g2_y_reg[lpr_pkg::POS_W-1] ? -g2_y_reg : g2_y_reg;
        sq_x  = abs_x[lpr_pkg::MAG_W-1:0] * abs_x[lpr_pkg::MAG_W-1:0];
        sq_y  = abs_y[lpr_pkg::MAG_W-1:0] * abs_y[lpr_pkg::MAG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_side_reg <= '0;
        else if (en)
            q_side_reg <= g2_side_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_n_reg <= lpr_pkg::SQ_N_W'(sq_x) + lpr_pkg::SQ_N_W'(sq_y);
    end

    // Square-root cell chain
    lpr_pkg::lpr_side_t            r_side [NSQ+1];
    logic [lpr_pkg::SQ_N_W-1:0]    r_n    [NSQ+1];
    logic [lpr_pkg::SQ_REM_W-1:0]  r_rem  [NSQ+1];
    logic [lpr_pkg::SQ_ROOT_W-1:0] r_root [NSQ+1];

    assign r_side[0] = q_side_reg;
    assign r_n[0]    = q_n_reg;
    assign r_rem[0]  = '0;
    assign r_root[0] = '0;

    for (genvar k = 0; k < NSQ; k++)
    begin : g_sqrt
        lpr_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .side_in  (r_side[k]),
            .n_in     (r_n[k]),
            .rem_in   (r_rem[k]),
            .root_in  (r_root[k]),
            .side_out (r_side[k+1]),
            .n_out    (r_n[k+1]),
            .rem_out  (r_rem[k+1]),
            .root_out (r_root[k+1])
        );
    end

    // Output stage: round to mm, saturate, pass infinite
    lpr_pkg::lpr_side_t o_side_reg;
    logic [15:0]        o_mm_reg;
    logic               o_sat_reg;
    logic [lpr_pkg::SQ_ROOT_W:0] mm_sum;
    logic [lpr_pkg::SQ_ROOT_W-4:0] mm_full;
    logic               mm_big;

    always_comb
    begin
        mm_sum  = {1'b0, r_root[NSQ]} + (lpr_pkg::SQ_ROOT_W+1)'(8);
        mm_full = mm_sum[lpr_pkg::SQ_ROOT_W:4];
        mm_big  = |mm_full[lpr_pkg::SQ_ROOT_W-4:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_side_reg <= '0;
        else if (en)
            o_side_reg <= r_side[NSQ];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (r_side[NSQ].inf)
            begin
                o_mm_reg  <= '0;
                o_sat_reg <= 1'b0;
            end
            else
            begin
                o_mm_reg  <= mm_big ? 16'hFFFF : mm_full[15:0];
                o_sat_reg <= mm_big;
            end
        end
    end

    // Advance the pipeline unless a finished word is held
    assign en       = !o_side_reg.valid || m_tready;
    assign s_tready = en;
    assign m_tvalid = o_side_reg.valid;
    assign m_tdata  = o_mm_reg;
    assign m_tuser  = {o_sat_reg, o_side_reg.inf};
    assign m_tlast  = o_side_reg.last;

    // Checks
    a_inf_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 16'd0 && !m_tuser[1]))
        else $error("infinite word carries range or saturation");

    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tdata == 16'hFFFF))
        else $error("saturated word not at full scale");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready disagrees with output stall");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(o_mm_reg) && $stable(o_sat_reg)))
        else $error("held output word changed");

endmodule
